// ----- src/assert_macros.svh -----
// Assertion macros used by the top level of the signature checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication: when cond holds, check holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, check, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, cond, check, msg)

`endif

`endif

// ----- src/dschk_pkg.sv -----
// Types, constants and the half-order table for the DER signature checker.
package dschk_pkg;

   localparam logic [7:0] SEQ_TAG      = 8'h30;
   localparam logic [7:0] INT_TAG      = 8'h02;
   localparam int         SIGN_BIT     = 7;
   localparam logic [6:0] MIN_LEN      = 7'd8;
   localparam logic [6:0] MAX_LEN      = 7'd72;
   localparam logic [6:0] COUNT_SAT    = 7'd73;
   localparam logic [7:0] S_FULL_LEN   = 8'd32;
   localparam logic [7:0] S_MAX_LEN    = 8'd33;

   // S against half the group order
   localparam logic [1:0] CMP_EQUAL    = 2'd0;
   localparam logic [1:0] CMP_LESS     = 2'd1;
   localparam logic [1:0] CMP_GREATER  = 2'd2;

   typedef struct packed {
      logic [6:0] byte_count;
      logic [7:0] seq_length;
      logic [7:0] r_length;
      logic [7:0] s_length;
      logic [7:0] r_first_byte;
      logic [7:0] s_first_byte;
      logic       refused;
      logic [1:0] compare_state;
   } dschk_state_type;

   localparam dschk_state_type STATE_RESET = '{
      byte_count:    7'd0,
      seq_length:    8'd0,
      r_length:      8'd0,
      s_length:      8'd0,
      r_first_byte:  8'd0,
      s_first_byte:  8'd0,
      refused:       1'b0,
      compare_state: CMP_EQUAL
   };

   // (n - 1) / 2 of the secp256k1 order, most significant byte first
   function automatic logic [7:0] half_order(input logic [4:0] idx);
      logic [7:0] val;
      case (idx)
         5'd0:    val = 8'h7f;
         5'd16:   val = 8'h5d;
         5'd17:   val = 8'h57;
         5'd18:   val = 8'h6e;
         5'd19:   val = 8'h73;
         5'd20:   val = 8'h57;
         5'd21:   val = 8'ha4;
         5'd22:   val = 8'h50;
         5'd23:   val = 8'h1d;
         5'd24:   val = 8'hdf;
         5'd25:   val = 8'he9;
         5'd26:   val = 8'h2f;
         5'd27:   val = 8'h46;
         5'd28:   val = 8'h68;
         5'd29:   val = 8'h1b;
         5'd30:   val = 8'h20;
         5'd31:   val = 8'ha0;
         default: val = 8'hff;
      endcase
      return val;
   endfunction

endpackage

// ----- src/dschk_core.sv -----
// Per-byte parse step and final verdict for the DER signature checker.
module dschk_core (
   input  dschk_pkg::dschk_state_type cur,
   input  logic [7:0]                 sig_byte,
   input  logic                       last,
   output dschk_pkg::dschk_state_type nxt,
   output logic                       verdict
);

   dschk_pkg::dschk_state_type upd;
   logic [6:0] pos;
   logic [7:0] rl;
   logic [8:0] pos9;
   logic [8:0] r_end;
   logic [9:0] k;
   logic [9:0] kp;
   logic [9:0] p;
   logic [7:0] ho;
   logic       bad;

   assign pos   = cur.byte_count;
   assign rl    = cur.r_length;
   assign pos9  = {2'b00, pos};
   assign r_end = 9'd4 + {1'b0, rl};
   assign k     = {3'b000, pos} - 10'd6 - {2'b00, rl};
   assign kp    = k + 10'd32;
   assign p     = kp - {2'b00, cur.s_length};
   assign ho    = dschk_pkg::half_order(p[4:0]);

   always_comb begin
      upd = cur;
      if (pos < dschk_pkg::COUNT_SAT) begin
         upd.byte_count = pos + 7'd1;
         if (pos == 7'd0) begin
            if (sig_byte != dschk_pkg::SEQ_TAG) upd.refused = 1'b1;
         end else if (pos == 7'd1) begin
            upd.seq_length = sig_byte;
         end else if (pos == 7'd2) begin
            if (sig_byte != dschk_pkg::INT_TAG) upd.refused = 1'b1;
         end else if (pos == 7'd3) begin
            upd.r_length = sig_byte;
            if (sig_byte == 8'd0) upd.refused = 1'b1;
         end else if (rl != 8'd0) begin
            if (pos9 < r_end) begin
               if (pos == 7'd4) begin
                  upd.r_first_byte = sig_byte;
                  if (sig_byte[dschk_pkg::SIGN_BIT]) upd.refused = 1'b1;
               end
               // redundant zero pad in front of R
               if (pos == 7'd5 && rl > 8'd1 && cur.r_first_byte == 8'd0
                   && !sig_byte[dschk_pkg::SIGN_BIT]) upd.refused = 1'b1;
            end else if (pos9 == r_end) begin
               if (sig_byte != dschk_pkg::INT_TAG) upd.refused = 1'b1;
            end else if (pos9 == r_end + 9'd1) begin
               upd.s_length = sig_byte;
               if (sig_byte == 8'd0) upd.refused = 1'b1;
               upd.compare_state = (sig_byte < dschk_pkg::S_FULL_LEN) ?
                                   dschk_pkg::CMP_LESS : dschk_pkg::CMP_EQUAL;
            end else if (k < {2'b00, cur.s_length}) begin
               if (k == 10'd0) begin
                  upd.s_first_byte = sig_byte;
                  if (sig_byte[dschk_pkg::SIGN_BIT]) upd.refused = 1'b1;
               end
               if (k == 10'd1 && cur.s_first_byte == 8'd0
                   && !sig_byte[dschk_pkg::SIGN_BIT]) upd.refused = 1'b1;
               // S aligned to the low end of the 32-byte half order
               if (kp >= {2'b00, cur.s_length} && p < 10'd32
                   && cur.compare_state == dschk_pkg::CMP_EQUAL) begin
                  if (sig_byte < ho) begin
                     upd.compare_state = dschk_pkg::CMP_LESS;
                  end else if (sig_byte > ho) begin
                     upd.compare_state = dschk_pkg::CMP_GREATER;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      bad = upd.refused;
      if (upd.byte_count < dschk_pkg::MIN_LEN || upd.byte_count > dschk_pkg::MAX_LEN)
         bad = 1'b1;
      if ({1'b0, upd.seq_length} + 9'd2 != {2'b00, upd.byte_count}) bad = 1'b1;
      if (upd.r_length == 8'd0 || upd.s_length == 8'd0) bad = 1'b1;
      if (10'd6 + {2'b00, upd.r_length} + {2'b00, upd.s_length}
          != {3'b000, upd.byte_count}) bad = 1'b1;
      if (upd.s_length > dschk_pkg::S_MAX_LEN) bad = 1'b1;
      if (upd.s_length == dschk_pkg::S_MAX_LEN && upd.s_first_byte != 8'd0) bad = 1'b1;
      if (upd.compare_state == dschk_pkg::CMP_GREATER) bad = 1'b1;
   end

   assign verdict = bad;
   assign nxt     = last ? dschk_pkg::STATE_RESET : upd;

endmodule

// ----- src/der_signature_standardness_check_top.sv -----
// Top level of the strict DER / low-S signature checker.
//
//   channel | direction | tdata              | tlast | words
//   req_    | in        | [7:0] sig_byte     | last  | one per signature byte
//   rsp_    | out       | [0] verdict        | none  | one per signature
//
// One byte per cycle sustained: the byte register feeds the parse step, whose
// result the state registers take directly; the verdict register takes the
// result of the last byte. A byte with last waits in the byte register only
// while a previous verdict is still untaken. Synchronous reset clears the
// parse state and both valid flags.
`include "assert_macros.svh"

module der_signature_standardness_check_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] sig_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] verdict, [7:1] zero
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       out_valid_ff, out_valid_in;
   logic       out_verdict_ff, out_verdict_in;
   logic       advance;
   logic       core_verdict;
   dschk_pkg::dschk_state_type state_ff, state_in, core_next;

   dschk_core u_core (
      .cur      (state_ff),
      .sig_byte (in_byte_ff),
      .last     (in_last_ff),
      .nxt      (core_next),
      .verdict  (core_verdict)
   );

   // a last word needs room in the verdict register
   assign advance    = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in    = req_tvalid ? 1'b1 : (in_valid_ff && !advance);
   assign state_in       = advance ? core_next : state_ff;
   assign out_valid_in   = (advance && in_last_ff) ? 1'b1 : (out_valid_ff && !rsp_tready);
   assign out_verdict_in = (advance && in_last_ff) ? core_verdict : out_verdict_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= dschk_pkg::STATE_RESET;
      end else begin
         in_valid_ff  <= req_tready ? in_valid_in : in_valid_ff;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      out_verdict_ff <= out_verdict_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_verdict_ff};

   `ASSERT_NEXT(a_last_gives_verdict, clock, reset, advance && in_last_ff, out_valid_ff, "last byte taken without a verdict")
   `ASSERT_NEXT(a_state_cleared, clock, reset, advance && in_last_ff, state_ff.byte_count == 7'd0, "state not cleared after verdict")
   `ASSERT_NEXT(a_count_step, clock, reset, advance && !in_last_ff && state_ff.byte_count < dschk_pkg::COUNT_SAT, state_ff.byte_count == $past(state_ff.byte_count) + 7'd1, "byte count did not step")
   `ASSERT_PROP(a_no_overwrite, clock, reset, !(in_valid_ff && in_last_ff && out_valid_ff && !rsp_tready && advance), "verdict overwritten while stalled")
   `ASSERT_PROP(a_count_sat, clock, reset, state_ff.byte_count <= dschk_pkg::COUNT_SAT, "byte count past saturation")

endmodule
